// File: rtl/core/rtip_pkg.sv
package rtip_pkg;

  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned COUNT_MAX = 65535;
  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned BASE_W    = 6;

  localparam logic [BASE_W-1:0] NO_DIGIT = 6'd36;
  localparam logic [BASE_W-1:0] BASE_8   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_10  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_16  = 6'd16;
  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic                negative;
    logic [BASE_W-1:0]   base;
    logic [BASE_W-1:0]   req_radix;
    logic [VALUE_W-1:0]  acc;
    logic [COUNT_W-1:0]  count;
  } parse_state_t;

  typedef struct packed {
    logic                emit;
    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  count;
  } parse_result_t;

  // Digit value of a character, NO_DIGIT for anything that is not 0-9, a-z, A-Z.
  function automatic logic [BASE_W-1:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd36;
      if (c inside {[8'h30:8'h39]}) begin
        d = c - 8'h30;
      end else if (c inside {[8'h61:8'h7A]}) begin
        d = c - 8'h57;
      end else if (c inside {[8'h41:8'h5A]}) begin
        d = c - 8'h37;
      end
      return d[BASE_W-1:0];
    end
  endfunction

endpackage

// File: rtl/core/rtip_step.sv
module rtip_step
  import rtip_pkg::*;
(
  input  parse_state_t  cur,
  input  logic [7:0]    text_char,
  input  logic          string_start,
  input  logic [5:0]    radix,
  output parse_state_t  nxt,
  output parse_result_t res
);

  parse_state_t       eff;
  phase_t             phase_next;
  logic               is_blank;
  logic               is_sign;
  logic               is_x;
  logic               zero_prefix;
  logic [BASE_W-1:0]  digit;
  logic [BASE_W-1:0]  dig_base;
  logic               digit_ok;
  logic               try_digit;
  logic [COUNT_W-1:0] count_inc;
  logic [VALUE_W-1:0] acc_step;

  // A start request drops whatever parse was under way before this character.
  always_comb begin
    eff = cur;
    if (string_start) begin
      eff.phase     = PH_SPACE;
      eff.negative  = 1'b0;
      eff.base      = BASE_AUTO;
      eff.req_radix = radix;
      eff.acc       = '0;
      eff.count     = '0;
    end
  end

  assign is_blank = (text_char == CH_SPACE) || (text_char == CH_TAB) ||
                    (text_char == CH_LF) || (text_char == CH_CR);
  assign is_sign  = (text_char == CH_PLUS) || (text_char == CH_MINUS);
  assign is_x     = (text_char == CH_LOW_X) || (text_char == CH_UP_X);
  assign zero_prefix = ((eff.req_radix == BASE_AUTO) || (eff.req_radix == BASE_16)) &&
                       (text_char == CH_ZERO);
  assign digit    = digit_of(text_char);
  assign count_inc = (eff.count < COUNT_W'(COUNT_MAX)) ? eff.count + 1'b1 : eff.count;

  // Base that applies to a digit taken in this cycle.
  always_comb begin
    case (eff.phase)
      PH_SPACE, PH_SIGNED: dig_base = (eff.req_radix == BASE_AUTO) ? BASE_10 : eff.req_radix;
      PH_ZERO:             dig_base = (eff.req_radix == BASE_AUTO) ? BASE_8 : BASE_16;
      default:             dig_base = eff.base;
    endcase
  end

  assign digit_ok = (digit < NO_DIGIT) && (digit < dig_base);
  assign acc_step = (eff.acc * {{(VALUE_W-BASE_W){1'b0}}, dig_base}) +
                    {{(VALUE_W-BASE_W){1'b0}}, digit};

  // Whether this character goes to the digit test.
  always_comb begin
    case (eff.phase)
      PH_SPACE:  try_digit = !is_blank && !is_sign && !zero_prefix;
      PH_SIGNED: try_digit = !zero_prefix;
      PH_ZERO:   try_digit = !is_x;
      PH_DIGITS: try_digit = 1'b1;
      default:   try_digit = 1'b0;
    endcase
  end

  // Next phase.
  always_comb begin
    phase_next = eff.phase;
    case (eff.phase)
      PH_SPACE: begin
        if (is_blank) begin
          phase_next = PH_SPACE;
        end else if (is_sign) begin
          phase_next = PH_SIGNED;
        end else if (zero_prefix) begin
          phase_next = PH_ZERO;
        end else begin
          phase_next = digit_ok ? PH_DIGITS : PH_IDLE;
        end
      end
      PH_SIGNED: begin
        if (zero_prefix) begin
          phase_next = PH_ZERO;
        end else begin
          phase_next = digit_ok ? PH_DIGITS : PH_IDLE;
        end
      end
      PH_ZERO: begin
        phase_next = (is_x || digit_ok) ? PH_DIGITS : PH_IDLE;
      end
      PH_DIGITS: begin
        phase_next = digit_ok ? PH_DIGITS : PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // Data fields and the result.
  always_comb begin
    nxt.phase     = phase_next;
    nxt.negative  = eff.negative;
    nxt.base      = eff.base;
    nxt.req_radix = eff.req_radix;
    nxt.acc       = eff.acc;
    nxt.count     = eff.count;
    res.emit      = 1'b0;
    res.value     = eff.negative ? (VALUE_W'(0) - eff.acc) : eff.acc;
    res.count     = eff.count;
    if (eff.phase != PH_IDLE) begin
      if (try_digit) begin
        nxt.base = dig_base;
        if (digit_ok) begin
          nxt.acc   = acc_step;
          nxt.count = count_inc;
        end else begin
          res.emit = 1'b1;
        end
      end else begin
        nxt.count = count_inc;
        if (eff.phase == PH_SPACE && is_sign) begin
          nxt.negative = (text_char == CH_MINUS);
        end
        if (eff.phase == PH_ZERO) begin
          nxt.base = BASE_16;
        end
      end
    end
  end

endmodule

// File: rtl/core/rtip_out_buf.sv
module rtip_out_buf
  import rtip_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [VALUE_W-1:0] wr_value,
  input  logic [COUNT_W-1:0] wr_count,
  output logic               space_ok,
  output logic [1:0]         level,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [VALUE_W-1:0] out_value,
  output logic [COUNT_W-1:0] out_count
);

  logic [VALUE_W-1:0] value_slot [2];
  logic [COUNT_W-1:0] count_slot [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic               rd_en;

  assign rd_en     = out_valid && out_ready;
  assign out_valid = (level != 2'd0);
  assign space_ok  = (level != 2'd2);
  assign out_value = value_slot[rd_ptr];
  assign out_count = count_slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      value_slot[wr_ptr] <= wr_value;
      count_slot[wr_ptr] <= wr_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   level <= level + 2'd1;
        2'b01:   level <= level - 2'd1;
        default: level <= level;
      endcase
    end
  end

endmodule

// File: rtl/core/radix_integer_text_parser_unit.sv
// Streaming strtol-style parser: one character is taken per cycle, with string_start
// marking the first character of a string and carrying its radix. When a character
// ends the number, its result (signed 64-bit value and saturating 16-bit count) is
// written into the result buffer and offered on the output channel. Throughput is one character
// per clock, set by the 64-by-6-bit multiply-add on the running value; a two-entry
// result buffer keeps input accepted while a result waits, so in_ready only drops
// when two results are pending.
module radix_integer_text_parser_unit
  import rtip_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                text_char,
  input  logic                      string_start,
  input  logic [5:0]                radix,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] parsed_value,
  output logic [COUNT_W-1:0]        consumed_count
);

  parse_state_t       state;
  parse_state_t       state_next;
  parse_result_t      res;
  logic               in_fire;
  logic [1:0]         level;
  logic [VALUE_W-1:0] value_u;

  assign in_fire = in_valid && in_ready;

  rtip_step u_step (
    .cur          (state),
    .text_char    (text_char),
    .string_start (string_start),
    .radix        (radix),
    .nxt          (state_next),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_IDLE, negative: 1'b0, base: '0, req_radix: '0,
                 acc: '0, count: '0};
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  rtip_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (in_fire && res.emit),
    .wr_value  (res.value),
    .wr_count  (res.count),
    .space_ok  (in_ready),
    .level     (level),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (value_u),
    .out_count (consumed_count)
  );

  assign parsed_value = $signed(value_u);

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level != 2'd3)
    else $error("result buffer level out of range");

  a_idle_ignore: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !string_start && state.phase == PH_IDLE) |=> level <= $past(level))
    else $error("character in idle phase produced a result");

  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    (in_fire && res.emit) |=> state.phase == PH_IDLE)
    else $error("parse did not return to idle after a result");

  a_digits_base: assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_DIGITS) |-> state.base != 6'd0)
    else $error("digit phase entered without a base");

endmodule

// File: bench/parse_checker.sv
module parse_checker
  import rtip_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [7:0]                text_char,
  input  logic                      string_start,
  input  logic [5:0]                radix,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [VALUE_W-1:0] parsed_value,
  input  logic [COUNT_W-1:0]        consumed_count,
  output int                        mismatches,
  output int                        awaited,
  output int                        checked
);

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } parsed_number_t;

  parsed_number_t awaited_numbers[$];

  phase_t              phase_q;
  logic                negative_q;
  logic [BASE_W-1:0]   base_q;
  logic [BASE_W-1:0]   req_q;
  logic [VALUE_W-1:0]  acc_q;
  logic [COUNT_W-1:0]  count_q;

  function automatic int char_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return c - 8'h30;
    end
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h61 + 10;
    end
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c - 8'h41 + 10;
    end
    return 36;
  endfunction

  task automatic bump_count();
    if (count_q < COUNT_MAX) begin
      count_q = count_q + 1'b1;
    end
  endtask

  task automatic close_number();
    parsed_number_t num;
    num.value = negative_q ? 64'd0 - acc_q : acc_q;
    num.count = count_q;
    awaited_numbers.push_back(num);
    phase_q = PH_IDLE;
  endtask

  task automatic take_digit(input logic [7:0] c);
    int d;
    d = char_digit(c);
    if (d < 36 && d < int'(base_q)) begin
      acc_q = acc_q * {58'd0, base_q} + 64'(d);
      bump_count();
      phase_q = PH_DIGITS;
    end else begin
      close_number();
    end
  endtask

  // A leading zero may still turn out to be the start of a hex prefix, so it
  // is held back until the next character decides the base.
  task automatic begin_number(input logic [7:0] c);
    if ((req_q == BASE_AUTO || req_q == BASE_16) && c == CH_ZERO) begin
      bump_count();
      phase_q = PH_ZERO;
    end else begin
      base_q = (req_q == BASE_AUTO) ? BASE_10 : req_q;
      take_digit(c);
    end
  endtask

  task automatic predict_char(input logic [7:0] c, input logic first, input logic [5:0] rdx);
    if (first) begin
      phase_q    = PH_SPACE;
      negative_q = 1'b0;
      base_q     = '0;
      req_q      = rdx;
      acc_q      = '0;
      count_q    = '0;
    end
    case (phase_q)
      PH_SPACE: begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
          bump_count();
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          negative_q = (c == CH_MINUS);
          bump_count();
          phase_q = PH_SIGNED;
        end else begin
          begin_number(c);
        end
      end
      PH_SIGNED: begin
        begin_number(c);
      end
      PH_ZERO: begin
        if (c == CH_LOW_X || c == CH_UP_X) begin
          base_q = BASE_16;
          bump_count();
          phase_q = PH_DIGITS;
        end else begin
          base_q = (req_q == BASE_AUTO) ? BASE_8 : BASE_16;
          take_digit(c);
        end
      end
      PH_DIGITS: begin
        take_digit(c);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    parsed_number_t want;
    if (rst) begin
      phase_q    = PH_IDLE;
      negative_q = 1'b0;
      base_q     = '0;
      req_q      = '0;
      acc_q      = '0;
      count_q    = '0;
      awaited_numbers.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      // Results are compared before the request of this edge is predicted:
      // a result never belongs to a character accepted at the same edge.
      if (out_valid && out_ready) begin
        if (awaited_numbers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected result: value %0d count %0d", parsed_value, consumed_count);
          end
        end else begin
          want = awaited_numbers.pop_front();
          checked++;
          if (parsed_value !== want.value || consumed_count !== want.count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: expected value %0d count %0d, got value %0d count %0d",
                       $signed(want.value), want.count, parsed_value, consumed_count);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_char(text_char, string_start, radix);
      end
    end
    awaited = awaited_numbers.size();
  end

endmodule

// File: bench/testbench.sv
module testbench;
  import rtip_pkg::*;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int RANDOM_CHARS  = 750;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_NUL   = 8'h00;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [7:0]                text_char;
  logic                      string_start;
  logic [5:0]                radix;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [VALUE_W-1:0] parsed_value;
  logic [COUNT_W-1:0]        consumed_count;

  int mismatches;
  int awaited;
  int checked;
  int cycles;
  int chars_sent;
  int strings_sent;
  bit steady_in;
  bit steady_out;

  radix_integer_text_parser_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .text_char      (text_char),
    .string_start   (string_start),
    .radix          (radix),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .parsed_value   (parsed_value),
    .consumed_count (consumed_count)
  );

  parse_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .text_char      (text_char),
    .string_start   (string_start),
    .radix          (radix),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .parsed_value   (parsed_value),
    .consumed_count (consumed_count),
    .mismatches     (mismatches),
    .awaited        (awaited),
    .checked        (checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Offers one character and returns at the edge where the request is taken.
  task automatic put_char(input logic [7:0] c, input logic first, input logic [5:0] rdx);
    int gap;
    logic rdy;
    gap = steady_in ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    text_char    <= c;
    string_start <= first;
    radix        <= rdx;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    chars_sent++;
  endtask

  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) begin
      return CH_ZERO + 8'(d);
    end
    return ($urandom_range(0, 1) ? CH_LOW_A : CH_UP_A) + 8'(d - 10);
  endfunction

  task automatic send_random_string();
    logic [7:0] chars[$];
    logic [5:0] rdx;
    int kind;
    int sel;
    int lim;
    int ndig;
    kind = $urandom_range(0, 9);
    strings_sent++;
    if ($urandom_range(0, 9) == 0) begin
      steady_in = !steady_in;
    end
    if (kind == 0) begin
      // Noise: arbitrary bytes, starts and radices.
      repeat ($urandom_range(1, 4)) begin
        put_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 6'($urandom_range(0, 63)));
      end
      return;
    end
    sel = $urandom_range(0, 7);
    case (sel)
      0, 1: rdx = BASE_AUTO;
      2: rdx = BASE_10;
      3: rdx = BASE_16;
      4: rdx = BASE_8;
      5: rdx = 6'd2;
      6: rdx = 6'($urandom_range(0, 63));
      default: rdx = ($urandom_range(0, 2) == 0) ? 6'd1 : 6'($urandom_range(36, 63));
    endcase
    lim = (rdx == BASE_AUTO) ? 10 : (rdx > 36 ? 36 : int'(rdx));
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        sel = $urandom_range(0, 3);
        chars.push_back(sel == 0 ? CH_SPACE : sel == 1 ? CH_TAB : sel == 2 ? CH_LF : CH_CR);
      end
    end
    sel = $urandom_range(0, 2);
    if (sel == 1) begin
      chars.push_back(CH_PLUS);
    end else if (sel == 2) begin
      chars.push_back(CH_MINUS);
    end
    if ((rdx == BASE_AUTO || rdx == BASE_16) && $urandom_range(0, 1)) begin
      chars.push_back(CH_ZERO);
      if ($urandom_range(0, 2) != 0) begin
        chars.push_back($urandom_range(0, 1) ? CH_LOW_X : CH_UP_X);
        lim = 16;
      end else if (rdx == BASE_AUTO) begin
        lim = 8;
      end
    end
    ndig = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
    repeat (ndig) chars.push_back(digit_char($urandom_range(0, lim - 1)));
    // Most strings are terminated; the rest are cut short by the next start.
    if (kind != 1) begin
      chars.push_back(($urandom_range(0, 3) == 0) ? CH_NUL : 8'($urandom_range(0, 255)));
    end
    if (chars.size() == 0) begin
      chars.push_back(8'($urandom_range(0, 255)));
    end
    foreach (chars[i]) begin
      put_char(chars[i], i == 0, (i == 0) ? rdx : 6'($urandom_range(0, 63)));
    end
    if ($urandom_range(0, 5) == 0) begin
      put_char(8'($urandom_range(0, 255)), 1'b0, 6'($urandom_range(0, 63)));
    end
  endtask

  // Result side: a fresh stall is drawn for every result taken.
  initial begin
    int gap;
    logic seen;
    out_ready  = 1'b0;
    steady_out = 1'b0;
    wait (rst == 1'b0);
    forever begin
      gap = steady_out ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        seen = out_valid;
        @(posedge clk);
      end while (!seen);
      if ($urandom_range(0, 9) == 0) begin
        steady_out = !steady_out;
      end
    end
  end

  initial begin
    int directed_chars;
    rst          = 1'b1;
    in_valid     = 1'b0;
    text_char    = '0;
    string_start = 1'b0;
    radix        = '0;
    steady_in    = 1'b0;
    chars_sent   = 0;
    strings_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // A character with no string open is ignored.
    put_char(8'h51, 1'b0, BASE_10);
    // Tab, minus, one digit, then NUL.
    put_char(CH_TAB, 1'b1, BASE_10);
    put_char(CH_MINUS, 1'b0, 6'd63);
    put_char(CH_ZERO + 8'd9, 1'b0, BASE_AUTO);
    put_char(CH_NUL, 1'b0, BASE_AUTO);
    // Detected hex with a prefix, stopped by a letter beyond f.
    put_char(CH_ZERO, 1'b1, BASE_AUTO);
    put_char(CH_LOW_X, 1'b0, BASE_AUTO);
    put_char(8'h46, 1'b0, BASE_AUTO);
    put_char(8'h67, 1'b0, BASE_AUTO);
    // A bare prefix still counts both characters.
    put_char(CH_ZERO, 1'b1, BASE_16);
    put_char(CH_UP_X, 1'b0, BASE_16);
    put_char(8'h23, 1'b0, BASE_16);
    // A leading zero selects octal, so 8 stops the number.
    put_char(CH_ZERO, 1'b1, BASE_AUTO);
    put_char(CH_ZERO + 8'd7, 1'b0, BASE_AUTO);
    put_char(CH_ZERO + 8'd8, 1'b0, BASE_AUTO);
    // Radix one accepts only zero.
    put_char(CH_ZERO, 1'b1, 6'd1);
    put_char(CH_ZERO + 8'd1, 1'b0, 6'd1);
    // Widest radix, top byte as terminator.
    put_char(8'h7A, 1'b1, 6'd63);
    put_char(8'hFF, 1'b0, 6'd63);
    // A blank after the sign ends the number.
    put_char(CH_PLUS, 1'b1, 6'd36);
    put_char(CH_SPACE, 1'b0, 6'd36);
    // A restart drops the open number without a result.
    put_char(CH_CR, 1'b1, BASE_10);
    put_char(CH_LF, 1'b0, BASE_10);
    put_char(CH_ZERO + 8'd5, 1'b1, BASE_10);
    put_char(8'h2E, 1'b0, BASE_10);
    put_char(CH_LOW_A, 1'b0, BASE_10);
    directed_chars = chars_sent;

    while (chars_sent < directed_chars + RANDOM_CHARS) begin
      send_random_string();
    end
    in_valid <= 1'b0;

    do begin
      @(negedge clk);
    end while (awaited != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d characters in %0d random strings plus directed cases.",
             chars_sent, strings_sent);
    $display("Compared %0d numbers, %0d mismatches, %0d still awaited.",
             checked, mismatches, awaited);
    if (mismatches == 0 && awaited == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/rtip_pkg.sv
rtl/core/rtip_step.sv
rtl/core/rtip_out_buf.sv
rtl/core/radix_integer_text_parser_unit.sv
bench/parse_checker.sv
bench/testbench.sv
